// File: rtl/cpu8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_pkg
// types, operation codes and flag helpers shared by the 8-bit execute unit
// ----------------------------------------------------------------------------
package cpu8_pkg;

  // operation codes, mnemonics in alphabetical order
  localparam logic [5:0] F_ADC = 6'd0;
  localparam logic [5:0] F_AND = 6'd1;
  localparam logic [5:0] F_ASL = 6'd2;
  localparam logic [5:0] F_BCC = 6'd3;
  localparam logic [5:0] F_BCS = 6'd4;
  localparam logic [5:0] F_BEQ = 6'd5;
  localparam logic [5:0] F_BIT = 6'd6;
  localparam logic [5:0] F_BMI = 6'd7;
  localparam logic [5:0] F_BNE = 6'd8;
  localparam logic [5:0] F_BPL = 6'd9;
  localparam logic [5:0] F_BVC = 6'd10;
  localparam logic [5:0] F_BVS = 6'd11;
  localparam logic [5:0] F_CLC = 6'd12;
  localparam logic [5:0] F_CLD = 6'd13;
  localparam logic [5:0] F_CLI = 6'd14;
  localparam logic [5:0] F_CLV = 6'd15;
  localparam logic [5:0] F_CMP = 6'd16;
  localparam logic [5:0] F_CPX = 6'd17;
  localparam logic [5:0] F_CPY = 6'd18;
  localparam logic [5:0] F_DEC = 6'd19;
  localparam logic [5:0] F_DEX = 6'd20;
  localparam logic [5:0] F_DEY = 6'd21;
  localparam logic [5:0] F_EOR = 6'd22;
  localparam logic [5:0] F_INC = 6'd23;
  localparam logic [5:0] F_INX = 6'd24;
  localparam logic [5:0] F_INY = 6'd25;
  localparam logic [5:0] F_JMP = 6'd26;
  localparam logic [5:0] F_JSR = 6'd27;
  localparam logic [5:0] F_LDA = 6'd28;
  localparam logic [5:0] F_LDX = 6'd29;
  localparam logic [5:0] F_LDY = 6'd30;
  localparam logic [5:0] F_LSR = 6'd31;
  localparam logic [5:0] F_NOP = 6'd32;
  localparam logic [5:0] F_ORA = 6'd33;
  localparam logic [5:0] F_PHA = 6'd34;
  localparam logic [5:0] F_PHP = 6'd35;
  localparam logic [5:0] F_PLA = 6'd36;
  localparam logic [5:0] F_PLP = 6'd37;
  localparam logic [5:0] F_ROL = 6'd38;
  localparam logic [5:0] F_ROR = 6'd39;
  localparam logic [5:0] F_RTI = 6'd40;
  localparam logic [5:0] F_RTS = 6'd41;
  localparam logic [5:0] F_SBC = 6'd42;
  localparam logic [5:0] F_SEC = 6'd43;
  localparam logic [5:0] F_SED = 6'd44;
  localparam logic [5:0] F_SEI = 6'd45;
  localparam logic [5:0] F_STA = 6'd46;
  localparam logic [5:0] F_STX = 6'd47;
  localparam logic [5:0] F_STY = 6'd48;
  localparam logic [5:0] F_TAX = 6'd49;
  localparam logic [5:0] F_TAY = 6'd50;
  localparam logic [5:0] F_TSX = 6'd51;
  localparam logic [5:0] F_TXA = 6'd52;
  localparam logic [5:0] F_TXS = 6'd53;
  localparam logic [5:0] F_TYA = 6'd54;

  // status bit positions, NV-BDIZC
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] BU_MASK    = 8'h30;

  typedef struct packed {
    logic [5:0]        func;
    logic [7:0]        operand;
    logic              accumulator_mode;
    logic [15:0]       address;
    logic signed [7:0] branch_offset;
    logic [15:0]       next_pc;
    logic [15:0]       return_address;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] pc_out;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  status_out;
    logic [7:0]  sp_out;
    logic [1:0]  extra_cycles;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_t;

  localparam arch_t ARCH_RESET = '{acc: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFD, p: 8'h24};

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q       = p;
    q[FL_Z] = (v == 8'h00);
    q[FL_N] = v[7];
    return q;
  endfunction

endpackage

// File: rtl/cpu_8bit_instruction_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_8bit_instruction_execute
// execute unit of a 6502-style processor with A, X, Y, SP and status
// ----------------------------------------------------------------------------
// two register stages: the input register in_r, then the result register out_r,
//   whose valid flag out_valid is set when the execute stage fires
// throughput: one instruction per cycle while out_ready does not stall; JSR holds
//   the execute stage since it emits two write transactions from the one stage
// reset (rst_n low, synchronous): both stages empty, A=X=Y=0, SP=0xFD, P=0x24
module cpu_8bit_instruction_execute (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpu8_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cpu8_pkg::out_t out_data
);
  import cpu8_pkg::*;

  logic  in_valid_r;
  in_t   in_r;
  logic  jsr_ph_r;
  logic  out_valid_r;
  out_t  out_r;
  arch_t st_r;

  out_t  res;
  arch_t st_nxt;
  logic  exe_fire;
  logic  exe_done;

  cpu8_exec u_exec (
    .item       (in_r),
    .st         (st_r),
    .jsr_second (jsr_ph_r),
    .res        (res),
    .st_nxt     (st_nxt)
  );

  assign exe_fire = in_valid_r && (!out_valid_r || out_ready);
  assign exe_done = exe_fire && res.last;
  assign in_ready = !in_valid_r || exe_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      jsr_ph_r    <= 1'b0;
      st_r        <= ARCH_RESET;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (exe_done) begin
        in_valid_r <= 1'b0;
      end
      if (exe_fire) begin
        out_valid_r <= 1'b1;
        jsr_ph_r    <= !res.last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (exe_done) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (exe_fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/cpu8_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_exec
// single-pass execute logic: one instruction against the register file,
// giving the result transaction and the next register state
// ----------------------------------------------------------------------------
module cpu8_exec (
  input  cpu8_pkg::in_t   item,
  input  cpu8_pkg::arch_t st,
  input  logic            jsr_second,
  output cpu8_pkg::out_t  res,
  output cpu8_pkg::arch_t st_nxt
);
  import cpu8_pkg::*;

  logic [7:0]  m;
  logic [7:0]  src;
  logic [7:0]  madd;
  logic [8:0]  sum9;
  logic [7:0]  cmp_reg;
  logic [8:0]  diff9;
  logic [7:0]  sh_r;
  logic        sh_c;
  logic [15:0] ret_pc;
  logic [15:0] tgt;
  logic        br_take;
  logic        we;
  logic [15:0] wa;
  logic [7:0]  wd;
  logic [15:0] pc;
  arch_t       n;

  assign m       = item.operand;
  assign src     = item.accumulator_mode ? st.acc : m;
  assign madd    = (item.func == F_SBC) ? ~m : m;
  assign sum9    = {1'b0, st.acc} + {1'b0, madd} + {8'h00, st.p[FL_C]};
  assign cmp_reg = (item.func == F_CPX) ? st.x : ((item.func == F_CPY) ? st.y : st.acc);
  assign diff9   = {1'b0, cmp_reg} - {1'b0, m};
  assign ret_pc  = item.next_pc - 16'd1;
  assign tgt     = item.next_pc + {{8{item.branch_offset[7]}}, item.branch_offset};

  always_comb begin
    unique case (item.func)
      F_ASL:   begin sh_r = {src[6:0], 1'b0};       sh_c = src[7]; end
      F_LSR:   begin sh_r = {1'b0, src[7:1]};       sh_c = src[0]; end
      F_ROL:   begin sh_r = {src[6:0], st.p[FL_C]}; sh_c = src[7]; end
      default: begin sh_r = {st.p[FL_C], src[7:1]}; sh_c = src[0]; end
    endcase
  end

  always_comb begin
    n       = st;
    we      = 1'b0;
    wa      = 16'h0000;
    wd      = 8'h00;
    pc      = item.next_pc;
    br_take = 1'b0;
    unique case (item.func)
      F_ADC, F_SBC: begin
        n.acc     = sum9[7:0];
        n.p[FL_C] = sum9[8];
        n.p[FL_V] = ~(st.acc[7] ^ madd[7]) & (st.acc[7] ^ sum9[7]);
        n.p       = set_nz(n.p, sum9[7:0]);
      end
      F_AND: begin n.acc = st.acc & m; n.p = set_nz(st.p, st.acc & m); end
      F_ORA: begin n.acc = st.acc | m; n.p = set_nz(st.p, st.acc | m); end
      F_EOR: begin n.acc = st.acc ^ m; n.p = set_nz(st.p, st.acc ^ m); end
      F_ASL, F_LSR, F_ROL, F_ROR: begin
        n.p       = set_nz(st.p, sh_r);
        n.p[FL_C] = sh_c;
        if (item.accumulator_mode) begin
          n.acc = sh_r;
        end else begin
          we = 1'b1;
          wa = item.address;
          wd = sh_r;
        end
      end
      F_BCC: br_take = ~st.p[FL_C];
      F_BCS: br_take = st.p[FL_C];
      F_BEQ: br_take = st.p[FL_Z];
      F_BNE: br_take = ~st.p[FL_Z];
      F_BMI: br_take = st.p[FL_N];
      F_BPL: br_take = ~st.p[FL_N];
      F_BVS: br_take = st.p[FL_V];
      F_BVC: br_take = ~st.p[FL_V];
      F_BIT: begin
        n.p[FL_Z] = ((st.acc & m) == 8'h00);
        n.p[FL_N] = m[7];
        n.p[FL_V] = m[6];
      end
      F_CLC: n.p[FL_C] = 1'b0;
      F_CLD: n.p[FL_D] = 1'b0;
      F_CLI: n.p[FL_I] = 1'b0;
      F_CLV: n.p[FL_V] = 1'b0;
      F_SEC: n.p[FL_C] = 1'b1;
      F_SED: n.p[FL_D] = 1'b1;
      F_SEI: n.p[FL_I] = 1'b1;
      F_CMP, F_CPX, F_CPY: begin
        n.p       = set_nz(st.p, diff9[7:0]);
        n.p[FL_C] = ~diff9[8];
      end
      F_DEC: begin
        we  = 1'b1;
        wa  = item.address;
        wd  = m - 8'd1;
        n.p = set_nz(st.p, m - 8'd1);
      end
      F_INC: begin
        we  = 1'b1;
        wa  = item.address;
        wd  = m + 8'd1;
        n.p = set_nz(st.p, m + 8'd1);
      end
      F_DEX: begin n.x = st.x - 8'd1; n.p = set_nz(st.p, st.x - 8'd1); end
      F_DEY: begin n.y = st.y - 8'd1; n.p = set_nz(st.p, st.y - 8'd1); end
      F_INX: begin n.x = st.x + 8'd1; n.p = set_nz(st.p, st.x + 8'd1); end
      F_INY: begin n.y = st.y + 8'd1; n.p = set_nz(st.p, st.y + 8'd1); end
      F_JMP: pc = item.address;
      F_JSR: begin
        we   = 1'b1;
        pc   = item.address;
        n.sp = st.sp - 8'd2;
        if (jsr_second) begin
          wa = {STACK_PAGE, st.sp - 8'd1};
          wd = ret_pc[7:0];
        end else begin
          wa = {STACK_PAGE, st.sp};
          wd = ret_pc[15:8];
        end
      end
      F_LDA: begin n.acc = m; n.p = set_nz(st.p, m); end
      F_LDX: begin n.x = m; n.p = set_nz(st.p, m); end
      F_LDY: begin n.y = m; n.p = set_nz(st.p, m); end
      F_PHA, F_PHP: begin
        we   = 1'b1;
        wa   = {STACK_PAGE, st.sp};
        wd   = (item.func == F_PHA) ? st.acc : (st.p | BU_MASK);
        n.sp = st.sp - 8'd1;
      end
      F_PLA: begin
        n.sp  = st.sp + 8'd1;
        n.acc = m;
        n.p   = set_nz(st.p, m);
      end
      F_PLP: begin
        n.p       = m;
        n.p[FL_B] = 1'b0;
        n.p[FL_U] = 1'b1;
        n.sp      = st.sp + 8'd1;
      end
      F_RTI: begin
        n.p       = m;
        n.p[FL_B] = 1'b0;
        n.p[FL_U] = 1'b1;
        n.sp      = st.sp + 8'd3;
        pc        = item.return_address;
      end
      F_RTS: begin
        n.sp = st.sp + 8'd2;
        pc   = item.return_address + 16'd1;
      end
      F_STA: begin we = 1'b1; wa = item.address; wd = st.acc; end
      F_STX: begin we = 1'b1; wa = item.address; wd = st.x; end
      F_STY: begin we = 1'b1; wa = item.address; wd = st.y; end
      F_TAX: begin n.x = st.acc; n.p = set_nz(st.p, st.acc); end
      F_TAY: begin n.y = st.acc; n.p = set_nz(st.p, st.acc); end
      F_TSX: begin n.x = st.sp; n.p = set_nz(st.p, st.sp); end
      F_TXA: begin n.acc = st.x; n.p = set_nz(st.p, st.x); end
      F_TXS: n.sp = st.x;
      F_TYA: begin n.acc = st.y; n.p = set_nz(st.p, st.y); end
      default: ;
    endcase
    if (br_take) begin
      pc = tgt;
    end
  end

  assign st_nxt = n;

  always_comb begin
    res.write_enable  = we;
    res.write_address = wa;
    res.write_data    = wd;
    res.pc_out        = pc;
    res.acc_out       = n.acc;
    res.x_out         = n.x;
    res.y_out         = n.y;
    res.status_out    = n.p;
    res.sp_out        = n.sp;
    if (!br_take) begin
      res.extra_cycles = 2'd0;
    end else if (tgt[15:8] != item.next_pc[15:8]) begin
      res.extra_cycles = 2'd2;
    end else begin
      res.extra_cycles = 2'd1;
    end
    res.last = (item.func != F_JSR) || jsr_second;
  end

endmodule

// File: rtl/cpu8_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_chk
// port-level checks for the execute unit, bound to the top level
// ----------------------------------------------------------------------------
module cpu8_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input cpu8_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input cpu8_pkg::out_t out_data
);
  import cpu8_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // first half of a stack push pair is followed at once by the last half
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.last && out_data.write_enable)
    else $error("split result not completed");

  // status always shows unused set and break clear
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status_out[FL_U] && !out_data.status_out[FL_B])
    else $error("bad status bits");

  // no write means zero address and data
  a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |->
      out_data.write_address == 16'h0000 && out_data.write_data == 8'h00)
    else $error("stray write fields");

  a_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.extra_cycles != 2'd3)
    else $error("extra cycles out of range");

endmodule

bind cpu_8bit_instruction_execute cpu8_chk u_chk (.*);

// File: tb/cpu8_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_exec_checker
// Watches both channels of the 8-bit execute unit. It keeps its own copy of
// A, X, Y, SP and P, predicts the result transactions of every accepted
// instruction and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module cpu8_exec_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  cpu8_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  cpu8_pkg::out_t out_data,
  output int             fail_count,
  output int             outstanding
);
  import cpu8_pkg::*;

  logic [7:0] reg_a, reg_x, reg_y, reg_sp, reg_p;
  out_t       predicted_results[$];
  out_t       want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic void update_nz(input logic [7:0] v);
    reg_p[FL_Z] = (v == 8'h00);
    reg_p[FL_N] = v[7];
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, reg_p[FL_C]};
    reg_p[FL_C] = sum[8];
    reg_p[FL_V] = ~(reg_a[7] ^ m[7]) & (reg_a[7] ^ sum[7]);
    reg_a = sum[7:0];
    update_nz(reg_a);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    reg_p[FL_C] = (r >= m);
    update_nz(diff);
  endfunction

  function automatic out_t snapshot(input logic we, input logic [15:0] wa,
                                    input logic [7:0] wd, input logic [15:0] pc,
                                    input logic [1:0] extra, input logic fin);
    out_t o;
    o.write_enable  = we;
    o.write_address = we ? wa : 16'h0000;
    o.write_data    = we ? wd : 8'h00;
    o.pc_out        = pc;
    o.acc_out       = reg_a;
    o.x_out         = reg_x;
    o.y_out         = reg_y;
    o.status_out    = reg_p;
    o.sp_out        = reg_sp;
    o.extra_cycles  = extra;
    o.last          = fin;
    return o;
  endfunction

  function automatic void execute_instr(input in_t ins);
    logic        we, is_branch, taken, cin, two_writes;
    logic [15:0] wa, pc, target, ret_pc;
    logic [7:0]  wd, src, r, sp0;
    logic [1:0]  extra;
    we         = 1'b0;
    is_branch  = 1'b0;
    taken      = 1'b0;
    two_writes = 1'b0;
    wa         = 16'h0000;
    wd         = 8'h00;
    pc         = ins.next_pc;
    extra      = 2'd0;
    case (ins.func)
      F_ADC: add_carry(ins.operand);
      F_SBC: add_carry(~ins.operand);
      F_AND: begin reg_a = reg_a & ins.operand; update_nz(reg_a); end
      F_ORA: begin reg_a = reg_a | ins.operand; update_nz(reg_a); end
      F_EOR: begin reg_a = reg_a ^ ins.operand; update_nz(reg_a); end
      F_ASL, F_LSR, F_ROL, F_ROR: begin
        src = ins.accumulator_mode ? reg_a : ins.operand;
        cin = reg_p[FL_C];
        case (ins.func)
          F_ASL: begin reg_p[FL_C] = src[7]; r = {src[6:0], 1'b0}; end
          F_LSR: begin reg_p[FL_C] = src[0]; r = {1'b0, src[7:1]}; end
          F_ROL: begin reg_p[FL_C] = src[7]; r = {src[6:0], cin}; end
          default: begin reg_p[FL_C] = src[0]; r = {cin, src[7:1]}; end
        endcase
        update_nz(r);
        if (ins.accumulator_mode) begin
          reg_a = r;
        end else begin
          we = 1'b1; wa = ins.address; wd = r;
        end
      end
      F_BCC: begin is_branch = 1'b1; taken = ~reg_p[FL_C]; end
      F_BCS: begin is_branch = 1'b1; taken = reg_p[FL_C]; end
      F_BEQ: begin is_branch = 1'b1; taken = reg_p[FL_Z]; end
      F_BNE: begin is_branch = 1'b1; taken = ~reg_p[FL_Z]; end
      F_BMI: begin is_branch = 1'b1; taken = reg_p[FL_N]; end
      F_BPL: begin is_branch = 1'b1; taken = ~reg_p[FL_N]; end
      F_BVS: begin is_branch = 1'b1; taken = reg_p[FL_V]; end
      F_BVC: begin is_branch = 1'b1; taken = ~reg_p[FL_V]; end
      F_BIT: begin
        reg_p[FL_Z] = ((reg_a & ins.operand) == 8'h00);
        reg_p[FL_N] = ins.operand[7];
        reg_p[FL_V] = ins.operand[6];
      end
      F_CLC: reg_p[FL_C] = 1'b0;
      F_CLD: reg_p[FL_D] = 1'b0;
      F_CLI: reg_p[FL_I] = 1'b0;
      F_CLV: reg_p[FL_V] = 1'b0;
      F_SEC: reg_p[FL_C] = 1'b1;
      F_SED: reg_p[FL_D] = 1'b1;
      F_SEI: reg_p[FL_I] = 1'b1;
      F_CMP: compare_reg(reg_a, ins.operand);
      F_CPX: compare_reg(reg_x, ins.operand);
      F_CPY: compare_reg(reg_y, ins.operand);
      F_DEC: begin
        r = ins.operand - 8'd1;
        update_nz(r);
        we = 1'b1; wa = ins.address; wd = r;
      end
      F_INC: begin
        r = ins.operand + 8'd1;
        update_nz(r);
        we = 1'b1; wa = ins.address; wd = r;
      end
      F_DEX: begin reg_x = reg_x - 8'd1; update_nz(reg_x); end
      F_DEY: begin reg_y = reg_y - 8'd1; update_nz(reg_y); end
      F_INX: begin reg_x = reg_x + 8'd1; update_nz(reg_x); end
      F_INY: begin reg_y = reg_y + 8'd1; update_nz(reg_y); end
      F_JMP: pc = ins.address;
      F_JSR: begin
        // return address minus one, high byte pushed first
        ret_pc = ins.next_pc - 16'd1;
        sp0    = reg_sp;
        reg_sp = reg_sp - 8'd2;
        predicted_results.push_back(snapshot(1'b1, {STACK_PAGE, sp0}, ret_pc[15:8],
                                             ins.address, 2'd0, 1'b0));
        predicted_results.push_back(snapshot(1'b1, {STACK_PAGE, sp0 - 8'd1}, ret_pc[7:0],
                                             ins.address, 2'd0, 1'b1));
        two_writes = 1'b1;
      end
      F_LDA: begin reg_a = ins.operand; update_nz(reg_a); end
      F_LDX: begin reg_x = ins.operand; update_nz(reg_x); end
      F_LDY: begin reg_y = ins.operand; update_nz(reg_y); end
      F_PHA: begin
        we = 1'b1; wa = {STACK_PAGE, reg_sp}; wd = reg_a;
        reg_sp = reg_sp - 8'd1;
      end
      F_PHP: begin
        we = 1'b1; wa = {STACK_PAGE, reg_sp}; wd = reg_p;
        wd[FL_B] = 1'b1;
        wd[FL_U] = 1'b1;
        reg_sp = reg_sp - 8'd1;
      end
      F_PLA: begin reg_sp = reg_sp + 8'd1; reg_a = ins.operand; update_nz(reg_a); end
      F_PLP, F_RTI: begin
        reg_p       = ins.operand;
        reg_p[FL_B] = 1'b0;
        reg_p[FL_U] = 1'b1;
        if (ins.func == F_PLP) begin
          reg_sp = reg_sp + 8'd1;
        end else begin
          reg_sp = reg_sp + 8'd3;
          pc     = ins.return_address;
        end
      end
      F_RTS: begin
        reg_sp = reg_sp + 8'd2;
        pc     = ins.return_address + 16'd1;
      end
      F_STA: begin we = 1'b1; wa = ins.address; wd = reg_a; end
      F_STX: begin we = 1'b1; wa = ins.address; wd = reg_x; end
      F_STY: begin we = 1'b1; wa = ins.address; wd = reg_y; end
      F_TAX: begin reg_x = reg_a; update_nz(reg_x); end
      F_TAY: begin reg_y = reg_a; update_nz(reg_y); end
      F_TSX: begin reg_x = reg_sp; update_nz(reg_x); end
      F_TXA: begin reg_a = reg_x; update_nz(reg_a); end
      F_TXS: reg_sp = reg_x;
      F_TYA: begin reg_a = reg_y; update_nz(reg_a); end
      default: ;
    endcase
    if (is_branch && taken) begin
      target = ins.next_pc + {{8{ins.branch_offset[7]}}, ins.branch_offset};
      extra  = (target[15:8] != ins.next_pc[15:8]) ? 2'd2 : 2'd1;
      pc     = target;
    end
    if (!two_writes) predicted_results.push_back(snapshot(we, wa, wd, pc, extra, 1'b1));
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_a  = 8'h00;
      reg_x  = 8'h00;
      reg_y  = 8'h00;
      reg_sp = 8'hFD;
      reg_p  = 8'h24;
      predicted_results.delete();
    end else begin
      if (in_valid && in_ready) execute_instr(in_data);
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transaction with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("write_enable", 16'(want.write_enable), 16'(out_data.write_enable));
          check_field("write_address", 16'(want.write_address), 16'(out_data.write_address));
          check_field("write_data", 16'(want.write_data), 16'(out_data.write_data));
          check_field("pc_out", want.pc_out, out_data.pc_out);
          check_field("acc_out", 16'(want.acc_out), 16'(out_data.acc_out));
          check_field("x_out", 16'(want.x_out), 16'(out_data.x_out));
          check_field("y_out", 16'(want.y_out), 16'(out_data.y_out));
          check_field("status_out", 16'(want.status_out), 16'(out_data.status_out));
          check_field("sp_out", 16'(want.sp_out), 16'(out_data.sp_out));
          check_field("extra_cycles", 16'(want.extra_cycles), 16'(out_data.extra_cycles));
          check_field("last", 16'(want.last), 16'(out_data.last));
        end
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives decoded instructions into the 8-bit execute unit: a directed run
// through flags, stack wrap, JSR/RTS/RTI and page-crossing branches, then
// random instructions with random idle gaps on both channels. The checker
// beside the unit predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
  import cpu8_pkg::*;

  localparam logic [5:0] F_UNDEF_TOP = 6'd63;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   fail_count;
  int   outstanding;
  int   sent;
  bit   tx_steady;

  cpu_8bit_instruction_execute DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cpu8_exec_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_t instr(input logic [5:0] f, input logic [7:0] opd,
                                input logic accm, input logic [15:0] addr,
                                input logic [7:0] off, input logic [15:0] npc,
                                input logic [15:0] ret);
    in_t t;
    t.func             = f;
    t.operand          = opd;
    t.accumulator_mode = accm;
    t.address          = addr;
    t.branch_offset    = off;
    t.next_pc          = npc;
    t.return_address   = ret;
    return t;
  endfunction

  function automatic in_t random_instr();
    in_t t;
    if ($urandom_range(0, 19) == 0) t.func = 6'($urandom_range(55, 63));
    else t.func = 6'($urandom_range(0, 54));
    t.operand = 8'($urandom);
    case ($urandom_range(0, 7))
      0: t.operand = 8'h00;
      1: t.operand = 8'hFF;
      2: t.operand = 8'h80;
      3: t.operand = 8'h7F;
      default: ;
    endcase
    t.accumulator_mode = 1'($urandom_range(0, 1));
    t.address          = 16'($urandom);
    t.branch_offset    = 8'($urandom);
    t.next_pc          = 16'($urandom);
    // land near a page edge so branches cross pages often
    if ($urandom_range(0, 3) == 0) t.next_pc[7:0] = {{6{t.next_pc[7]}}, t.next_pc[1:0]};
    t.return_address = 16'($urandom);
    if ($urandom_range(0, 15) == 0) t.return_address = 16'hFFFF;
    return t;
  endfunction

  task automatic send(input in_t item);
    int gap;
    if (sent % 40 == 0) tx_steady = ($urandom_range(0, 2) == 0);
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    int taken;
    bit steady;
    out_ready <= 1'b0;
    taken = 0;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int n;
    sent = 0;
    tx_steady = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // arithmetic edges, flag handling, branches and JSR/RTS/RTI
    send(instr(F_LDA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0000, 16'h0000));
    send(instr(F_LDA, 8'h7F, 1'b0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send(instr(F_ADC, 8'h01, 1'b0, 16'h0000, 8'h00, 16'h0200, 16'h0000));
    send(instr(F_ADC, 8'hFF, 1'b0, 16'h0000, 8'h00, 16'h0202, 16'h0000));
    send(instr(F_SBC, 8'h01, 1'b0, 16'h0000, 8'h00, 16'h0204, 16'h0000));
    send(instr(F_BIT, 8'hC0, 1'b0, 16'h0000, 8'h00, 16'h0206, 16'h0000));
    send(instr(F_SED, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0207, 16'h0000));
    send(instr(F_PHP, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0208, 16'h0000));
    // pulled status keeps break clear
    send(instr(F_PLP, 8'hFF, 1'b0, 16'h0000, 8'h00, 16'h0209, 16'h0000));
    send(instr(F_BCS, 8'h00, 1'b0, 16'h0000, 8'h7F, 16'h12F0, 16'h0000));
    send(instr(F_BEQ, 8'h00, 1'b0, 16'h0000, 8'h80, 16'h0000, 16'h0000));
    send(instr(F_BVS, 8'h00, 1'b0, 16'h0000, 8'h05, 16'h0010, 16'h0000));
    send(instr(F_CLC, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0020, 16'h0000));
    send(instr(F_BCS, 8'h00, 1'b0, 16'h0000, 8'h10, 16'h0021, 16'h0000));
    send(instr(F_JSR, 8'h00, 1'b0, 16'hFFFF, 8'h00, 16'h0000, 16'h0000));
    send(instr(F_RTS, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h1234, 16'hFFFF));
    send(instr(F_RTI, 8'h10, 1'b0, 16'h0000, 8'h00, 16'h1234, 16'hABCD));
    // stack pointer wrap through zero
    send(instr(F_LDX, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0300, 16'h0000));
    send(instr(F_TXS, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0302, 16'h0000));
    send(instr(F_PHA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0303, 16'h0000));
    send(instr(F_PLA, 8'h80, 1'b0, 16'h0000, 8'h00, 16'h0304, 16'h0000));
    // shifts on A ignore the operand and write nothing; memory shifts, DEC, INC and STA write
    send(instr(F_ASL, 8'h55, 1'b1, 16'h1111, 8'h00, 16'h0305, 16'h0000));
    send(instr(F_LSR, 8'h01, 1'b0, 16'hFFFF, 8'h00, 16'h0306, 16'h0000));
    send(instr(F_ROR, 8'h80, 1'b0, 16'h0000, 8'h00, 16'h0308, 16'h0000));
    send(instr(F_ROL, 8'hAA, 1'b1, 16'h0000, 8'h00, 16'h030A, 16'h0000));
    send(instr(F_DEC, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h030B, 16'h0000));
    send(instr(F_INC, 8'hFF, 1'b0, 16'hFFFF, 8'h00, 16'h030D, 16'h0000));
    send(instr(F_STA, 8'h00, 1'b0, 16'hFFFF, 8'h00, 16'h030F, 16'h0000));
    send(instr(F_UNDEF_TOP, 8'hFF, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    drain();

    for (n = 0; n < 850; n++) begin
      send(random_instr());
      if (n % 200 == 199) drain();
    end
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
